@@ hdl/met_pkg.sv @@
// Shared types and constants for the escape-time unit: fixed-point widths,
// multiplier operand codes, register indexes and the controller/datapath bundles.
// No dependencies.
package met_pkg;

    // Fixed-point format of c and z.
    localparam int FRAC_BITS = 28;

    // Register and field widths.
    localparam int COORD_W = 32;
    localparam int STEP_W  = 31;
    localparam int LIMIT_W = 16;
    localparam int RW_W    = 13;
    localparam int PIX_W   = 12;
    localparam int ADDR_W  = 24;
    localparam int MAG_OUT_W = 38;
    localparam int TOTAL_W   = 40;
    localparam int INSIDE_W  = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Iteration datapath widths. A running z stays well inside 36 bits signed.
    localparam int Z_W    = 36;
    localparam int HALF_W = Z_W / 2;
    localparam int PROD_W = Z_W + HALF_W;
    localparam int SQ_W   = 2 * Z_W - FRAC_BITS;
    localparam int SUM_W  = SQ_W + 1;
    localparam int CPROD_W = STEP_W + PIX_W;

    // Escape threshold 25 in the |z|^2 format, and output saturation limits.
    localparam logic [SUM_W-1:0]     ESC_THRESH = SUM_W'(25) << FRAC_BITS;
    localparam logic [MAG_OUT_W-1:0] MAG_MAX    = '1;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX  = '1;
    localparam logic [INSIDE_W-1:0]  INSIDE_MAX = '1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RWIDTH    = 3'd5;

    // Register reset values.
    localparam logic [COORD_W-1:0] ORIGIN_RE_RST = 32'hE000_0000;
    localparam logic [COORD_W-1:0] ORIGIN_IM_RST = 32'hE800_0000;
    localparam logic [STEP_W-1:0]  STEP_RE_RST   = 31'd786432;
    localparam logic [STEP_W-1:0]  STEP_IM_RST   = 31'd786432;
    localparam logic [LIMIT_W-1:0] LIMIT_RST     = 16'd256;
    localparam logic [RW_W-1:0]    RWIDTH_RST    = 13'd1024;

    // Multiplier operand selection.
    localparam logic [1:0] MUL_RE_SQ = 2'd0;
    localparam logic [1:0] MUL_IM_SQ = 2'd1;
    localparam logic [1:0] MUL_CROSS = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       load_c;
        logic       mul_issue;
        logic [1:0] mul_sel;
        logic       mul_hi;
        logic       step_z;
        logic       commit;
    } met_cmd_t;

    typedef struct packed {
        logic at_limit;
        logic escaped;
    } met_status_t;

endpackage

@@ hdl/met_ctrl.sv @@
// Sequencer for the escape-time unit: handshakes, iteration schedule of the
// shared multiplier and the output slot. Depends on met_pkg.
module met_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  met_pkg::met_status_t  status,
    output met_pkg::met_cmd_t     cmd
);
    import met_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_SQ0  = 4'd2;
    localparam logic [3:0] S_SQ1  = 4'd3;
    localparam logic [3:0] S_SQ2  = 4'd4;
    localparam logic [3:0] S_SQ3  = 4'd5;
    localparam logic [3:0] S_SQ4  = 4'd6;
    localparam logic [3:0] S_SQ5  = 4'd7;
    localparam logic [3:0] S_SQ6  = 4'd8;
    localparam logic [3:0] S_STEP = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_c = 1'b1;
                state_next = S_SQ0;
            end
            S_SQ0:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_sel   = MUL_RE_SQ;
                state_next    = S_SQ1;
            end
            S_SQ1:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_sel   = MUL_RE_SQ;
                cmd.mul_hi    = 1'b1;
                state_next    = S_SQ2;
            end
            S_SQ2:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_sel   = MUL_IM_SQ;
                state_next    = S_SQ3;
            end
            S_SQ3:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_sel   = MUL_IM_SQ;
                cmd.mul_hi    = 1'b1;
                state_next    = S_SQ4;
            end
            S_SQ4:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_sel   = MUL_CROSS;
                state_next    = S_SQ5;
            end
            S_SQ5:
            begin
                // Both squares are settled here; the cross product is
                // started ahead of the test and simply dropped on exit.
                cmd.mul_issue = 1'b1;
                cmd.mul_sel   = MUL_CROSS;
                cmd.mul_hi    = 1'b1;
                if (status.at_limit || status.escaped)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SQ6;
                end
            end
            S_SQ6:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step_z = 1'b1;
                state_next = S_SQ0;
            end
            S_DONE:
            begin
                cmd.commit = !out_valid_reg || !out_stall;
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/met_dpath.sv @@
// Datapath of the escape-time unit: registers, point setup, the shared
// split multiplier, z update, statistics and result registers. Depends on met_pkg.
module met_dpath #(
    parameter int MAX_RASTER_WIDTH = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  met_pkg::met_cmd_t                 cmd,
    output met_pkg::met_status_t              status,
    input  logic                              cfg_we,
    input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [met_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [met_pkg::PIX_W-1:0]         pixel_x,
    input  logic [met_pkg::PIX_W-1:0]         pixel_y,
    input  logic                              clear_stats,
    output logic [met_pkg::ADDR_W-1:0]        pixel_address,
    output logic [met_pkg::LIMIT_W-1:0]       escape_count,
    output logic                              inside_res,
    output logic [met_pkg::MAG_OUT_W-1:0]     final_magnitude_sq,
    output logic [met_pkg::LIMIT_W-1:0]       min_escape_count,
    output logic [met_pkg::LIMIT_W-1:0]       max_escape_count,
    output logic [met_pkg::TOTAL_W-1:0]       total_count,
    output logic [met_pkg::INSIDE_W-1:0]      inside_total
);
    import met_pkg::*;

    localparam int MW_W  = $clog2(MAX_RASTER_WIDTH + 1);
    localparam int CW    = (MW_W > RW_W) ? MW_W : RW_W;
    localparam int APROD_W = CW + PIX_W;
    localparam int CSUM_W  = CPROD_W + 2;
    localparam int ZN_W    = SQ_W + 2;
    localparam logic [CW-1:0] W_MAX = CW'(MAX_RASTER_WIDTH);

    // Configuration registers.
    logic [COORD_W-1:0] origin_re_reg, origin_im_reg;
    logic [STEP_W-1:0]  step_re_reg, step_im_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [RW_W-1:0]    rwidth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg <= ORIGIN_RE_RST;
            origin_im_reg <= ORIGIN_IM_RST;
            step_re_reg   <= STEP_RE_RST;
            step_im_reg   <= STEP_IM_RST;
            limit_reg     <= LIMIT_RST;
            rwidth_reg    <= RWIDTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_RE: origin_re_reg <= cfg_data;
                CFG_ORIGIN_IM: origin_im_reg <= cfg_data;
                CFG_STEP_RE:   step_re_reg   <= cfg_data[STEP_W-1:0];
                CFG_STEP_IM:   step_im_reg   <= cfg_data[STEP_W-1:0];
                CFG_LIMIT:     limit_reg     <= cfg_data[LIMIT_W-1:0];
                CFG_RWIDTH:    rwidth_reg    <= cfg_data[RW_W-1:0];
                default:       ;
            endcase
        end
    end

    // Capture: the offsets and the row product are formed straight from the request.
    logic [CPROD_W-1:0] coff_re_reg, coff_im_reg;
    logic [APROD_W-1:0] row_reg;
    logic [PIX_W-1:0]   px_reg;
    logic               clr_reg;
    logic [CW-1:0]      rwidth_ext, w_eff;

    assign rwidth_ext = CW'(rwidth_reg);
    assign w_eff      = (rwidth_ext > W_MAX) ? W_MAX : rwidth_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            coff_re_reg <= CPROD_W'(step_re_reg) * CPROD_W'(pixel_x);
            coff_im_reg <= CPROD_W'(step_im_reg) * CPROD_W'(pixel_y);
            row_reg     <= APROD_W'(w_eff) * APROD_W'(pixel_y);
            px_reg      <= pixel_x;
            clr_reg     <= clear_stats;
        end
    end

    // Point setup with saturation to the 32-bit signed range.
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic [COORD_W-1:0] origin,
        input logic [CPROD_W-1:0] offs
    );
        logic signed [CSUM_W-1:0] sum;
        logic signed [CSUM_W-1:0] lim_hi;
        logic signed [CSUM_W-1:0] lim_lo;
        sum    = $signed({{(CSUM_W-COORD_W){origin[COORD_W-1]}}, origin})
               + $signed({2'b00, offs});
        lim_hi = $signed({{(CSUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
        lim_lo = $signed({{(CSUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}});
        if (sum > lim_hi)
        begin
            sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (sum < lim_lo)
        begin
            sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            sat_coord = sum[COORD_W-1:0];
        end
    endfunction

    logic signed [COORD_W-1:0] cre_reg, cim_reg;
    logic signed [Z_W-1:0]     zre_reg, zim_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [LIMIT_W-1:0]        k_reg;
    logic [APROD_W:0]          addr_sum;
    logic signed [COORD_W-1:0] cre_new, cim_new;

    assign addr_sum = {1'b0, row_reg} + (APROD_W+1)'(px_reg);
    assign cre_new  = sat_coord(origin_re_reg, coff_re_reg);
    assign cim_new  = sat_coord(origin_im_reg, coff_im_reg);

    // Shared multiplier: a magnitude times one half of the other, registered.
    logic [Z_W-1:0]    mag_re, mag_im, op_a, op_b;
    logic [HALF_W-1:0] op_b_half;
    logic [PROD_W-1:0] prod_next, prod_reg, acc_reg;
    logic              tag_valid_reg;
    logic [1:0]        tag_sel_reg;
    logic              tag_hi_reg;
    logic [PROD_W+HALF_W-1:0] full_prod;
    logic [SQ_W-1:0]   prod_shifted;
    logic [SQ_W-1:0]   sq_re_reg, sq_im_reg, cross_reg;

    assign mag_re = zre_reg[Z_W-1] ? Z_W'(-zre_reg) : Z_W'(zre_reg);
    assign mag_im = zim_reg[Z_W-1] ? Z_W'(-zim_reg) : Z_W'(zim_reg);

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_RE_SQ:
            begin
                op_a = mag_re;
                op_b = mag_re;
            end
            MUL_IM_SQ:
            begin
                op_a = mag_im;
                op_b = mag_im;
            end
            MUL_CROSS:
            begin
                op_a = {mag_re[Z_W-2:0], 1'b0};
                op_b = mag_im;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign op_b_half = cmd.mul_hi ? op_b[2*HALF_W-1:HALF_W] : op_b[HALF_W-1:0];
    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b_half);

    // Upper half lands HALF_W bits up; the sum is truncated by the fraction width.
    assign full_prod    = {{HALF_W{1'b0}}, acc_reg} + {prod_reg, {HALF_W{1'b0}}};
    assign prod_shifted = full_prod[PROD_W+HALF_W-1:FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            tag_valid_reg <= cmd.mul_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        tag_sel_reg <= cmd.mul_sel;
        tag_hi_reg  <= cmd.mul_hi;
        if (tag_valid_reg && !tag_hi_reg)
        begin
            acc_reg <= prod_reg;
        end
        if (tag_valid_reg && tag_hi_reg)
        begin
            unique case (tag_sel_reg)
                MUL_RE_SQ: sq_re_reg <= prod_shifted;
                MUL_IM_SQ: sq_im_reg <= prod_shifted;
                MUL_CROSS: cross_reg <= prod_shifted;
                default:   ;
            endcase
        end
    end

    // z update: re = re^2 - im^2 + c_re, im = +/-(2 re im) + c_im.
    logic [SUM_W-1:0]       magsq;
    logic signed [ZN_W-1:0] zre_wide, zim_wide, cross_s;
    logic                   cross_neg;

    assign magsq     = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    assign cross_neg = zre_reg[Z_W-1] ^ zim_reg[Z_W-1];
    assign cross_s   = cross_neg ? -$signed({2'b00, cross_reg}) : $signed({2'b00, cross_reg});
    assign zre_wide  = $signed({2'b00, sq_re_reg}) - $signed({2'b00, sq_im_reg})
                     + $signed({{(ZN_W-COORD_W){cre_reg[COORD_W-1]}}, cre_reg});
    assign zim_wide  = cross_s
                     + $signed({{(ZN_W-COORD_W){cim_reg[COORD_W-1]}}, cim_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load_c)
        begin
            cre_reg  <= cre_new;
            cim_reg  <= cim_new;
            zre_reg  <= Z_W'(cre_new);
            zim_reg  <= Z_W'(cim_new);
            addr_reg <= addr_sum[ADDR_W-1:0];
            k_reg    <= '0;
        end
        else if (cmd.step_z)
        begin
            zre_reg <= zre_wide[Z_W-1:0];
            zim_reg <= zim_wide[Z_W-1:0];
            k_reg   <= k_reg + 1'b1;
        end
    end

    assign status.at_limit = (k_reg == limit_reg);
    assign status.escaped  = (magsq > ESC_THRESH);

    // Statistics, with the clear applied ahead of this pixel.
    logic [LIMIT_W-1:0]  stat_min_reg, stat_max_reg;
    logic [TOTAL_W-1:0]  stat_total_reg;
    logic [INSIDE_W-1:0] stat_inside_reg;
    logic [LIMIT_W-1:0]  base_min, base_max;
    logic [TOTAL_W-1:0]  base_total;
    logic [INSIDE_W-1:0] base_inside;
    logic [TOTAL_W:0]    total_sum;

    assign base_min    = clr_reg ? limit_reg : stat_min_reg;
    assign base_max    = clr_reg ? '0 : stat_max_reg;
    assign base_total  = clr_reg ? '0 : stat_total_reg;
    assign base_inside = clr_reg ? '0 : stat_inside_reg;
    assign total_sum   = {1'b0, base_total} + (TOTAL_W+1)'(k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_min_reg    <= LIMIT_RST;
            stat_max_reg    <= '0;
            stat_total_reg  <= '0;
            stat_inside_reg <= '0;
        end
        else if (cmd.commit)
        begin
            stat_total_reg <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
            stat_max_reg   <= (!status.at_limit && (k_reg > base_max)) ? k_reg : base_max;
            stat_min_reg   <= ((k_reg != '0) && (k_reg < base_min)) ? k_reg : base_min;
            stat_inside_reg <= (status.at_limit && (base_inside != INSIDE_MAX))
                             ? base_inside + 1'b1 : base_inside;
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            pixel_address      <= addr_reg;
            escape_count       <= k_reg;
            inside_res         <= status.at_limit;
            final_magnitude_sq <= (magsq > SUM_W'(MAG_MAX)) ? MAG_MAX : magsq[MAG_OUT_W-1:0];
        end
    end

    assign min_escape_count = stat_min_reg;
    assign max_escape_count = stat_max_reg;
    assign total_count      = stat_total_reg;
    assign inside_total     = stat_inside_reg;

endmodule

@@ hdl/mandelbrot_escape_time_unit.sv @@
// Mandelbrot escape-time unit: one pixel request in, one result out.
// Top level; depends on met_pkg, met_ctrl and met_dpath.
//
// Each request names a pixel; the unit forms c = origin + step * index on both axes
// (signed Q4.28, saturated to 32 bits) and iterates z = z^2 + c from z = c until
// |z|^2 exceeds 25 or iteration_limit steps are done. One pixel is in flight at a
// time. Until the next request can be taken, a pixel passes the setup state, then
// per step the squares, cross product, magnitude test and z update, then a last
// round of squares with the final magnitude test, the commit and the return to
// idle. Each step is paced by the single 36x18-bit multiplier, which forms re^2,
// im^2 and 2*re*im as two half products each. A finished result sits in the output
// register, and the next request is accepted while it waits to be taken. The running
// statistics outputs follow the result and change only when the next result is
// committed. Registers are written through the configuration port, which is always
// ready; writes are expected only while no pixel is in progress.
module mandelbrot_escape_time_unit #(
    parameter int MAX_RASTER_WIDTH = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Pixel requests.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [met_pkg::PIX_W-1:0]         pixel_x,
    input  logic [met_pkg::PIX_W-1:0]         pixel_y,
    input  logic                              clear_stats,
    // Results.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [met_pkg::ADDR_W-1:0]        pixel_address,
    output logic [met_pkg::LIMIT_W-1:0]       escape_count,
    output logic                              inside_res,
    output logic [met_pkg::MAG_OUT_W-1:0]     final_magnitude_sq,
    output logic [met_pkg::LIMIT_W-1:0]       min_escape_count,
    output logic [met_pkg::LIMIT_W-1:0]       max_escape_count,
    output logic [met_pkg::TOTAL_W-1:0]       total_count,
    output logic [met_pkg::INSIDE_W-1:0]      inside_total,
    // Register writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [met_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import met_pkg::*;

    met_cmd_t    cmd;
    met_status_t status;
    logic        cfg_we;

    // Register writes never wait.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    met_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    met_dpath #(
        .MAX_RASTER_WIDTH (MAX_RASTER_WIDTH)
    ) u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .pixel_x            (pixel_x),
        .pixel_y            (pixel_y),
        .clear_stats        (clear_stats),
        .pixel_address      (pixel_address),
        .escape_count       (escape_count),
        .inside_res         (inside_res),
        .final_magnitude_sq (final_magnitude_sq),
        .min_escape_count   (min_escape_count),
        .max_escape_count   (max_escape_count),
        .total_count        (total_count),
        .inside_total       (inside_total)
    );

endmodule

@@ sim/met_escape_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the escape-time unit: tracks register writes, predicts each
// pixel result and compares it with what the unit returns. Depends on met_pkg.
module met_escape_checker
    import met_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel_x,
    input  logic [PIX_W-1:0]      pixel_y,
    input  logic                  clear_stats,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [ADDR_W-1:0]     pixel_address,
    input  logic [LIMIT_W-1:0]    escape_count,
    input  logic                  inside_res,
    input  logic [MAG_OUT_W-1:0]  final_magnitude_sq,
    input  logic [LIMIT_W-1:0]    min_escape_count,
    input  logic [LIMIT_W-1:0]    max_escape_count,
    input  logic [TOTAL_W-1:0]    total_count,
    input  logic [INSIDE_W-1:0]   inside_total,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending,
    output int                    compared
);

    localparam int          RASTER_CAP   = 4096;
    localparam logic [63:0] ESCAPE_LEVEL = 64'd25 << FRAC_BITS;
    localparam logic [63:0] PRODUCT_CAP  = 64'h4000_0000_0000_0000;
    localparam longint      COORD_HI     = 64'sd2147483647;
    localparam longint      COORD_LO     = -64'sd2147483648;

    typedef struct packed {
        logic [ADDR_W-1:0]    address;
        logic [LIMIT_W-1:0]   count;
        logic                 is_inside;
        logic [MAG_OUT_W-1:0] magnitude_sq;
        logic [LIMIT_W-1:0]   min_count;
        logic [LIMIT_W-1:0]   max_count;
        logic [TOTAL_W-1:0]   total;
        logic [INSIDE_W-1:0]  inside_cnt;
    } pixel_result_t;

    // Register copies and running statistics as the unit should hold them.
    logic signed [COORD_W-1:0] view_re;
    logic signed [COORD_W-1:0] view_im;
    logic [STEP_W-1:0]         pitch_re;
    logic [STEP_W-1:0]         pitch_im;
    logic [LIMIT_W-1:0]        max_iter;
    logic [RW_W-1:0]           row_width;
    logic [LIMIT_W-1:0]        run_min;
    logic [LIMIT_W-1:0]        run_max;
    logic [TOTAL_W-1:0]        run_total;
    logic [INSIDE_W-1:0]       run_inside;

    pixel_result_t expected_pixels[$];
    pixel_result_t want;

    // Magnitude product, truncated by the fraction width and capped at 2^62.
    function automatic logic [63:0] fx_mul_mag(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = 128'(a) * 128'(b);
        prod = prod >> FRAC_BITS;
        if (prod > {64'd0, PRODUCT_CAP})
            prod = {64'd0, PRODUCT_CAP};
        return prod[63:0];
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [63:0] m;
        m = fx_mul_mag(magnitude(a), magnitude(b));
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] abs_sq(longint re, longint im);
        return fx_mul_mag(magnitude(re), magnitude(re)) + fx_mul_mag(magnitude(im), magnitude(im));
    endfunction

    function automatic longint pixel_coord(logic signed [COORD_W-1:0] origin,
                                           logic [STEP_W-1:0] pitch, logic [PIX_W-1:0] idx);
        longint v;
        longint offset;
        offset = longint'({33'd0, pitch}) * longint'({52'd0, idx});
        v = longint'(origin) + offset;
        if (v > COORD_HI)
            v = COORD_HI;
        if (v < COORD_LO)
            v = COORD_LO;
        return v;
    endfunction

    // Runs one pixel through the iteration and folds it into the statistics.
    function automatic pixel_result_t escape_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                                                   logic clr);
        pixel_result_t r;
        longint        c_re, c_im, z_re, z_im, nxt;
        logic [63:0]   m;
        logic [31:0]   w, addr;
        logic [TOTAL_W:0] sum;
        int unsigned   k;
        c_re = pixel_coord(view_re, pitch_re, px);
        c_im = pixel_coord(view_im, pitch_im, py);
        z_re = c_re;
        z_im = c_im;
        if (clr)
        begin
            run_min    = max_iter;
            run_max    = '0;
            run_total  = '0;
            run_inside = '0;
        end
        k = 0;
        while (k < max_iter)
        begin
            if (abs_sq(z_re, z_im) > ESCAPE_LEVEL)
                break;
            nxt  = fx_mul(z_re, z_re) - fx_mul(z_im, z_im) + c_re;
            z_im = fx_mul(2 * z_re, z_im) + c_im;
            z_re = nxt;
            k++;
        end
        m = abs_sq(z_re, z_im);
        if (m > 64'(MAG_MAX))
            m = 64'(MAG_MAX);
        sum = {1'b0, run_total} + (TOTAL_W+1)'(k);
        run_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        if (k < max_iter && k > run_max)
            run_max = k[LIMIT_W-1:0];
        if (k > 0 && k < run_min)
            run_min = k[LIMIT_W-1:0];
        if (k == max_iter && run_inside != INSIDE_MAX)
            run_inside++;
        w = (row_width > RASTER_CAP) ? RASTER_CAP : 32'(row_width);
        addr = w * 32'(py) + 32'(px);
        r.address      = addr[ADDR_W-1:0];
        r.count        = k[LIMIT_W-1:0];
        r.is_inside    = (k == max_iter);
        r.magnitude_sq = m[MAG_OUT_W-1:0];
        r.min_count    = run_min;
        r.max_count    = run_max;
        r.total        = run_total;
        r.inside_cnt   = run_inside;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_re    = ORIGIN_RE_RST;
            view_im    = ORIGIN_IM_RST;
            pitch_re   = STEP_RE_RST;
            pitch_im   = STEP_IM_RST;
            max_iter   = LIMIT_RST;
            row_width  = RWIDTH_RST;
            run_min    = LIMIT_RST;
            run_max    = '0;
            run_total  = '0;
            run_inside = '0;
            expected_pixels.delete();
            mismatches = 0;
            compared   = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ORIGIN_RE: view_re   = cfg_data;
                    CFG_ORIGIN_IM: view_im   = cfg_data;
                    CFG_STEP_RE:   pitch_re  = cfg_data[STEP_W-1:0];
                    CFG_STEP_IM:   pitch_im  = cfg_data[STEP_W-1:0];
                    CFG_LIMIT:     max_iter  = cfg_data[LIMIT_W-1:0];
                    CFG_RWIDTH:    row_width = cfg_data[RW_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_pixels.push_back(escape_pixel(pixel_x, pixel_y, clear_stats));
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result for address %0h arrived with none expected",
                                 $realtime, pixel_address);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    compared++;
                    check_field("pixel_address", 64'(want.address), 64'(pixel_address));
                    check_field("escape_count", 64'(want.count), 64'(escape_count));
                    check_field("inside_res", 64'(want.is_inside), 64'(inside_res));
                    check_field("final_magnitude_sq", 64'(want.magnitude_sq),
                                64'(final_magnitude_sq));
                    check_field("min_escape_count", 64'(want.min_count), 64'(min_escape_count));
                    check_field("max_escape_count", 64'(want.max_count), 64'(max_escape_count));
                    check_field("total_count", 64'(want.total), 64'(total_count));
                    check_field("inside_total", 64'(want.inside_cnt), 64'(inside_total));
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Top of the escape-time unit testbench: clock, reset, request and register
// stimulus, result stalls and the verdict. Depends on met_pkg and met_escape_checker.
module tb;
    import met_pkg::*;

    // The slowest legal quiet stretch is one inside pixel at a limit of 256
    // plus the longest result stall and request gap; the watchdog allows
    // several times that.
    localparam int WATCHDOG_LIMIT = 10000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel_x;
    logic [PIX_W-1:0]      pixel_y;
    logic                  clear_stats;
    logic                  out_valid;
    logic                  out_stall;
    logic [ADDR_W-1:0]     pixel_address;
    logic [LIMIT_W-1:0]    escape_count;
    logic                  inside_res;
    logic [MAG_OUT_W-1:0]  final_magnitude_sq;
    logic [LIMIT_W-1:0]    min_escape_count;
    logic [LIMIT_W-1:0]    max_escape_count;
    logic [TOTAL_W-1:0]    total_count;
    logic [INSIDE_W-1:0]   inside_total;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int compared;
    int requests_sent;
    int settings_used;
    int stuck_cycles;

    mandelbrot_escape_time_unit i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .pixel_x            (pixel_x),
        .pixel_y            (pixel_y),
        .clear_stats        (clear_stats),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .pixel_address      (pixel_address),
        .escape_count       (escape_count),
        .inside_res         (inside_res),
        .final_magnitude_sq (final_magnitude_sq),
        .min_escape_count   (min_escape_count),
        .max_escape_count   (max_escape_count),
        .total_count        (total_count),
        .inside_total       (inside_total),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // The checker watches all three channels and keeps its own copy of the
    // registers and statistics; the top only reads its counters.
    met_escape_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .pixel_x            (pixel_x),
        .pixel_y            (pixel_y),
        .clear_stats        (clear_stats),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .pixel_address      (pixel_address),
        .escape_count       (escape_count),
        .inside_res         (inside_res),
        .final_magnitude_sq (final_magnitude_sq),
        .min_escape_count   (min_escape_count),
        .max_escape_count   (max_escape_count),
        .total_count        (total_count),
        .inside_total       (inside_total),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (mismatches),
        .pending            (pending),
        .compared           (compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result-side backpressure. Mostly short bursts of stall and no stall, with
    // an occasional long free-running stretch and an occasional long stall so
    // that stalls land on every phase of the iteration.
    initial
    begin
        int pick;
        int hold;
        out_stall = 1'b0;
        forever
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                out_stall = 1'b0;
                hold = $urandom_range(1, 4);
            end
            else if (pick < 80)
            begin
                out_stall = 1'b1;
                hold = $urandom_range(1, 3);
            end
            else if (pick < 90)
            begin
                out_stall = 1'b0;
                hold = $urandom_range(30, 120);
            end
            else
            begin
                out_stall = 1'b1;
                hold = $urandom_range(20, 60);
            end
            repeat (hold) @(negedge clk);
        end
    end

    // Any accepted transfer on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("DONE: errors detected");
        $finish;
    end

    // Request gaps: usually none or a few cycles, now and then a long pause.
    function automatic int request_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Waits for the unit to drain, then writes all six registers back to back.
    // Called and returns on a falling edge.
    task automatic load_view(input logic [31:0] o_re, input logic [31:0] o_im,
                             input logic [31:0] s_re, input logic [31:0] s_im,
                             input logic [15:0] lim, input logic [12:0] rw);
        logic [CFG_DATA_W-1:0] values [6];
        logic [CFG_IDX_W-1:0]  targets [6];
        while (pending != 0)
            @(negedge clk);
        targets[0] = CFG_ORIGIN_RE;  values[0] = o_re;
        targets[1] = CFG_ORIGIN_IM;  values[1] = o_im;
        targets[2] = CFG_STEP_RE;    values[2] = s_re;
        targets[3] = CFG_STEP_IM;    values[3] = s_im;
        targets[4] = CFG_LIMIT;      values[4] = {16'd0, lim};
        targets[5] = CFG_RWIDTH;     values[5] = {19'd0, rw};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid = 1'b1;
            cfg_index = targets[i];
            cfg_data  = values[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid = 1'b0;
        settings_used++;
    endtask

    // Presents one pixel request and holds it until the unit takes it. Valid
    // stays high across back-to-back requests; it only drops for a gap.
    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                              input logic clr, input bit back_to_back);
        int gap;
        in_valid    = 1'b1;
        pixel_x     = x;
        pixel_y     = y;
        clear_stats = clr;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        requests_sent++;
        gap = back_to_back ? 0 : request_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        int           kind;
        int           pick;
        int           o_re;
        int           o_im;
        logic [31:0]  s_re;
        logic [31:0]  s_im;
        logic [15:0]  lim;
        logic [12:0]  rw;
        bit           burst;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        pixel_x       = '0;
        pixel_y       = '0;
        clear_stats   = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_ORIGIN_RE;
        cfg_data      = '0;
        requests_sent = 0;
        settings_used = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset view: corners of the raster, two points deep inside the set
        // that run the full 256 steps, and a clear in the middle of the stream.
        send_pixel(12'd0, 12'd0, 1'b0, 1'b0);
        send_pixel(12'd4095, 12'd4095, 1'b0, 1'b0);
        send_pixel(12'd683, 12'd512, 1'b0, 1'b0);
        send_pixel(12'd512, 12'd512, 1'b0, 1'b0);
        send_pixel(12'd1023, 12'd0, 1'b0, 1'b1);
        send_pixel(12'd300, 12'd400, 1'b1, 1'b0);
        send_pixel(12'd0, 12'd4095, 1'b0, 1'b0);
        send_pixel(12'd4095, 12'd0, 1'b0, 1'b0);
        in_valid = 1'b0;

        // Zero limit: no step is taken and every pixel is inside. Zero raster
        // width makes the address the column alone. The clear reloads the
        // minimum from a limit of zero.
        load_view(32'hE000_0000, 32'hE800_0000, 32'd786432, 32'd786432, 16'd0, 13'd0);
        send_pixel(12'd100, 12'd200, 1'b1, 1'b0);
        send_pixel(12'd4095, 12'd4095, 1'b0, 1'b0);
        send_pixel(12'd683, 12'd512, 1'b0, 1'b0);
        in_valid = 1'b0;

        // Largest limit with c pushed to both ends of the signed range, so
        // each axis saturates; the widest raster width is capped for the
        // address. Every point escapes before the first step.
        load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,
                  13'h1FFF);
        send_pixel(12'd0, 12'd0, 1'b1, 1'b0);
        send_pixel(12'd4095, 12'd4095, 1'b0, 1'b0);
        send_pixel(12'd4095, 12'd0, 1'b0, 1'b0);
        send_pixel(12'd0, 12'd4095, 1'b0, 1'b0);
        in_valid = 1'b0;

        // Largest limit again; points from 1+i to 6+i escape at once or after
        // one or two steps, and a raster width just above the cap.
        load_view(32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 32'd0, 16'hFFFF, 13'd4097);
        send_pixel(12'd0, 12'd7, 1'b0, 1'b0);
        send_pixel(12'd1, 12'd4095, 1'b0, 1'b0);
        send_pixel(12'd5, 12'd1, 1'b0, 1'b0);
        send_pixel(12'd3, 12'd0, 1'b1, 1'b0);
        in_valid = 1'b0;

        // Limit of one at c = -0.5: every pixel is inside after a single step.
        load_view(32'hF800_0000, 32'd0, 32'd0, 32'd0, 16'd1, 13'd1);
        send_pixel(12'd2048, 12'd2048, 1'b1, 1'b0);
        send_pixel(12'd1, 12'd1, 1'b0, 1'b1);
        send_pixel(12'd4095, 12'd4095, 1'b0, 1'b0);
        in_valid = 1'b0;

        // Random views. Most frame a window around the set so that pixels run
        // long, varied orbits; some use fully random registers, where c mostly
        // lands far outside. Pixels mostly fall in the window, a few anywhere.
        for (int ph = 0; ph < 12; ph++)
        begin
            kind  = $urandom_range(0, 9);
            burst = ($urandom_range(0, 3) == 0);
            if (kind == 0)
            begin
                o_re = $urandom;
                o_im = $urandom;
                s_re = $urandom;
                s_im = $urandom;
                lim  = 16'($urandom_range(1, 256));
                rw   = 13'($urandom_range(0, 8191));
            end
            else
            begin
                o_re = -671088640 + int'($urandom_range(0, 805306368));
                o_im = -int'($urandom_range(0, 536870912));
                s_re = $urandom_range(1 << 16, 1 << 21);
                s_im = $urandom_range(1 << 16, 1 << 21);
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    lim = 16'($urandom_range(8, 64));
                else if (pick < 9)
                    lim = 16'($urandom_range(65, 200));
                else
                    lim = 16'($urandom_range(1, 7));
                rw = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(1, 4096));
            end
            load_view(o_re, o_im, s_re, s_im, lim, rw);
            for (int n = 0; n < 75; n++)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    x = PIX_W'($urandom_range(0, 4095));
                    y = PIX_W'($urandom_range(0, 4095));
                end
                else
                begin
                    x = PIX_W'($urandom_range(0, 255));
                    y = PIX_W'($urandom_range(0, 255));
                end
                send_pixel(x, y, ($urandom_range(0, 15) == 0), burst);
            end
            in_valid = 1'b0;
        end

        // Drain, then give the unit a little time to show any stray result.
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d pixel requests over %0d register settings; %0d results compared.",
                 requests_sent, settings_used + 1, compared);
        if (mismatches == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
